// ----- sv/pcs_pkg.sv -----
package pcs_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int COORD_WIDTH     = 16;

  localparam int ANGLE_W  = 15;
  localparam int DIST_W   = 16;
  localparam int SCALE_W  = 20;
  localparam int ORIGIN_W = 10;
  localparam int YOFF_W   = 10;
  localparam int STEP_W   = 15;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SCALE_W;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE          = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE_STEP = CFG_IDX_W'(4);

  localparam logic [SCALE_W-1:0]  SCALE_RESET    = SCALE_W'(13107);
  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET = ORIGIN_W'(240);
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET = ORIGIN_W'(136);
  localparam logic [STEP_W-1:0]   MAX_STEP_RESET = STEP_W'(640);

  // Bearing reduction. The quotient by a quarter turn comes from a reciprocal
  // multiply that is exact for every 15-bit bearing.
  localparam int    QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
  localparam int    RECIP_SH     = 36;
  localparam longint RECIP       = (longint'(1) << RECIP_SH) / QUARTER_TURN + 1;
  localparam int    QPROD_W      = ANGLE_W + RECIP_SH;

  // CORDIC.
  localparam int CORDIC_STEPS = 20;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int TRIG_W       = 32;
  localparam int Z_W          = 25;
  localparam int Z_SHIFT      = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = TRIG_W'(652032874);

  // Projection datapath.
  localparam int MAG_W     = TRIG_W - 7;
  localparam int P1_W      = DIST_W + MAG_W;
  localparam int LO_W      = (P1_W + 1) / 2;
  localparam int HI_W      = P1_W - LO_W;
  localparam int MUL_A_W   = (MAG_W > LO_W) ? MAG_W : LO_W;
  localparam int MUL_B_W   = (SCALE_W > DIST_W) ? SCALE_W : DIST_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int PROD_W    = P1_W + SCALE_W;
  localparam int RND_SHIFT = 24 + SCALE_FRAC_BITS;
  localparam int R_W       = PROD_W - RND_SHIFT + 1;
  localparam int OFF_W     = ORIGIN_W + 2;
  localparam int SUM_W     = (R_W + 2 > COORD_WIDTH + 1) ? R_W + 2 : COORD_WIDTH + 1;
  localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((longint'(1) << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [SUM_W-1:0] COORD_MIN = -COORD_MAX - SUM_W'(1);

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
    logic               scan_start;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] from_x;
    logic signed [COORD_WIDTH-1:0] from_y;
    logic signed [COORD_WIDTH-1:0] to_x;
    logic signed [COORD_WIDTH-1:0] to_y;
    logic                          draw_segment;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic [DIST_W-1:0]        distance;
    logic signed [TRIG_W-1:0] trig;
    logic [SCALE_W-1:0]       scale;
    logic signed [OFF_W-1:0]  offset;
  } proj_req_t;

  // Arctangent of 2^-i in degrees, 16 fraction bits.
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      ITER_W'(0):  v = Z_W'(2949120);
      ITER_W'(1):  v = Z_W'(1740967);
      ITER_W'(2):  v = Z_W'(919879);
      ITER_W'(3):  v = Z_W'(466945);
      ITER_W'(4):  v = Z_W'(234379);
      ITER_W'(5):  v = Z_W'(117304);
      ITER_W'(6):  v = Z_W'(58666);
      ITER_W'(7):  v = Z_W'(29335);
      ITER_W'(8):  v = Z_W'(14668);
      ITER_W'(9):  v = Z_W'(7334);
      ITER_W'(10): v = Z_W'(3667);
      ITER_W'(11): v = Z_W'(1833);
      ITER_W'(12): v = Z_W'(917);
      ITER_W'(13): v = Z_W'(458);
      ITER_W'(14): v = Z_W'(229);
      ITER_W'(15): v = Z_W'(115);
      ITER_W'(16): v = Z_W'(57);
      ITER_W'(17): v = Z_W'(29);
      ITER_W'(18): v = Z_W'(14);
      ITER_W'(19): v = Z_W'(7);
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/pcs_cordic.sv -----
module pcs_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pcs_pkg::Z_W-1:0]    z0,
  output logic                              done,
  output logic signed [pcs_pkg::TRIG_W-1:0] cos_q,
  output logic signed [pcs_pkg::TRIG_W-1:0] sin_q
);
  import pcs_pkg::*;

  logic signed [TRIG_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]    z_r, z_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;
  logic                     run_r, run_nxt, done_r, done_nxt;
  logic signed [TRIG_W-1:0] dx, dy;
  logic signed [Z_W-1:0]    ang;

  // One shared add/sub and barrel shift per axis, one rotation per cycle.
  assign dx  = y_r >>> iter_r;
  assign dy  = x_r >>> iter_r;
  assign ang = atan_q16(iter_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    iter_nxt = iter_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = z0;
      iter_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!z_r[Z_W-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - ang;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + ang;
      end
      if (iter_r == ITER_W'(CORDIC_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        iter_nxt = iter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done  = done_r;
  assign cos_q = x_r;
  assign sin_q = y_r;

endmodule

// ----- sv/pcs_project.sv -----
module pcs_project (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pcs_pkg::proj_req_t                     req,
  output logic                                   done,
  output logic signed [pcs_pkg::COORD_WIDTH-1:0] coord
);
  import pcs_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE, P_MAG, P_M1, P_M2, P_M3, P_RND, P_SUM
  } pstate_t;

  pstate_t                       state_r, state_nxt;
  logic                          done_r, done_nxt;
  logic                          neg_r, neg_nxt;
  logic [MAG_W-1:0]              mag24_r, mag24_nxt;
  logic [P1_W-1:0]               p1_r, p1_nxt;
  logic [LO_W+SCALE_W-1:0]       lo_r, lo_nxt;
  logic [PROD_W-1:0]             acc_r, acc_nxt;
  logic [R_W-1:0]                r_r, r_nxt;
  logic signed [COORD_WIDTH-1:0] coord_r, coord_nxt;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [TRIG_W:0]    mag_rnd;
  logic [PROD_W:0]    acc_rnd;
  logic signed [SUM_W-1:0] mag_s, val;

  // The one multiplier serves the distance product and both halves of the
  // scale product.
  assign mul_p = mul_a * mul_b;

  always_comb begin
    unique case (state_r)
      P_M1:    begin
        mul_a = MUL_A_W'(mag24_r);
        mul_b = MUL_B_W'(req.distance);
      end
      P_M2:    begin
        mul_a = MUL_A_W'(p1_r[LO_W-1:0]);
        mul_b = MUL_B_W'(req.scale);
      end
      P_M3:    begin
        mul_a = MUL_A_W'(p1_r[P1_W-1:LO_W]);
        mul_b = MUL_B_W'(req.scale);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mag_rnd = (req.trig[TRIG_W-1] ? (TRIG_W+1)'(-req.trig) : (TRIG_W+1)'(req.trig))
              + (TRIG_W+1)'(32);
    acc_rnd = (PROD_W+1)'(acc_r) + ((PROD_W+1)'(1) << (RND_SHIFT - 1));
    mag_s   = SUM_W'(r_r);
    val     = (neg_r ? -mag_s : mag_s) + SUM_W'(req.offset);
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    mag24_nxt = mag24_r;
    p1_nxt    = p1_r;
    lo_nxt    = lo_r;
    acc_nxt   = acc_r;
    r_nxt     = r_r;
    coord_nxt = coord_r;
    unique case (state_r)
      P_IDLE: begin
        if (req.start) state_nxt = P_MAG;
      end
      P_MAG: begin
        neg_nxt   = req.trig[TRIG_W-1];
        mag24_nxt = mag_rnd[MAG_W+5:6];
        state_nxt = P_M1;
      end
      P_M1: begin
        p1_nxt    = mul_p[P1_W-1:0];
        state_nxt = P_M2;
      end
      P_M2: begin
        lo_nxt    = mul_p[LO_W+SCALE_W-1:0];
        state_nxt = P_M3;
      end
      P_M3: begin
        acc_nxt   = PROD_W'(lo_r) + (PROD_W'(mul_p[HI_W+SCALE_W-1:0]) << LO_W);
        state_nxt = P_RND;
      end
      P_RND: begin
        r_nxt     = acc_rnd[RND_SHIFT +: R_W];
        state_nxt = P_SUM;
      end
      P_SUM: begin
        priority if (val > COORD_MAX) coord_nxt = COORD_MAX[COORD_WIDTH-1:0];
        else if (val < COORD_MIN)     coord_nxt = COORD_MIN[COORD_WIDTH-1:0];
        else                          coord_nxt = val[COORD_WIDTH-1:0];
        done_nxt  = 1'b1;
        state_nxt = P_IDLE;
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    neg_r   <= neg_nxt;
    mag24_r <= mag24_nxt;
    p1_r    <= p1_nxt;
    lo_r    <= lo_nxt;
    acc_r   <= acc_nxt;
    r_r     <= r_nxt;
    coord_r <= coord_nxt;
  end

  assign done  = done_r;
  assign coord = coord_r;

endmodule

// ----- sv/polar_scan_to_segments.sv -----
// One sample at a time: in_stall stays high from an input beat until its result
// is placed at the output. The 20-step CORDIC loop and the shared multiplier
// (six products per sample) set the pace, and a stalled output also holds it.
// A new sample is taken while the previous result still waits at the output.
// Reset (rst_n low at a clock edge) empties the block, loads the register
// defaults and forgets the previous point.
module polar_scan_to_segments (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pcs_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pcs_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pcs_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE, T_QUOT, T_REM, T_CSTART, T_CWAIT, T_MAP,
    T_PX, T_PXW, T_PY, T_PYW, T_OUT
  } tstate_t;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;

  tstate_t state_r, state_nxt;

  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  logic [ORIGIN_W-1:0]      origin_x_r, origin_x_nxt, origin_y_r, origin_y_nxt;
  logic signed [YOFF_W-1:0] y_offset_r, y_offset_nxt;
  logic [STEP_W-1:0]        max_step_r, max_step_nxt;

  logic [ANGLE_W-1:0]       angle_r, angle_nxt;
  logic [DIST_W-1:0]        dist_r, dist_nxt;
  logic                     scan_r, scan_nxt;
  logic [ANGLE_W-1:0]       quot_r, quot_nxt;
  logic signed [Z_W-1:0]    z0_r, z0_nxt;
  logic signed [TRIG_W-1:0] sn_r, sn_nxt, cs_r, cs_nxt;
  logic signed [COORD_WIDTH-1:0] to_x_r, to_x_nxt, to_y_r, to_y_nxt;

  logic signed [COORD_WIDTH-1:0] prev_col_r, prev_col_nxt, prev_row_r, prev_row_nxt;
  logic [ANGLE_W-1:0]       prev_bearing_r, prev_bearing_nxt;
  logic                     prev_pos_r, prev_pos_nxt, have_prev_r, have_prev_nxt;

  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [QPROD_W-1:0]       qprod;
  logic [ANGLE_W-1:0]       rem;
  logic signed [ANGLE_W:0]  step;
  logic                     first, draw;
  logic                     doing_y;
  logic signed [OFF_W-1:0]  x_off, y_off;

  logic                     cord_done;
  logic signed [TRIG_W-1:0] cord_cos, cord_sin;
  proj_req_t                preq;
  logic                     proj_done;
  logic signed [COORD_WIDTH-1:0] proj_coord;

  assign in_stall  = (state_r != T_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign qprod = QPROD_W'(angle_r) * QPROD_W'(RECIP);
  assign rem   = angle_r - ANGLE_W'(quot_r * QUARTER_TURN);

  assign x_off   = $signed({2'b00, origin_x_r});
  assign y_off   = $signed({2'b00, origin_y_r}) + OFF_W'(y_offset_r);
  assign doing_y = (state_r == T_PY) || (state_r == T_PYW);

  always_comb begin
    preq.start    = (state_r == T_PX) || (state_r == T_PY);
    preq.distance = dist_r;
    preq.trig     = doing_y ? cs_r : sn_r;
    preq.scale    = scale_r;
    preq.offset   = doing_y ? y_off : x_off;
  end

  // The join test uses the raw bearings as a signed difference.
  assign step  = $signed({1'b0, angle_r}) - $signed({1'b0, prev_bearing_r});
  assign first = scan_r || !have_prev_r;
  assign draw  = !first && (dist_r != '0) && prev_pos_r
                 && (step < $signed({1'b0, max_step_r}));

  pcs_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == T_CSTART),
    .z0    (z0_r),
    .done  (cord_done),
    .cos_q (cord_cos),
    .sin_q (cord_sin)
  );

  pcs_project u_project (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (preq),
    .done  (proj_done),
    .coord (proj_coord)
  );

  always_comb begin
    state_nxt        = state_r;
    scale_nxt        = scale_r;
    origin_x_nxt     = origin_x_r;
    origin_y_nxt     = origin_y_r;
    y_offset_nxt     = y_offset_r;
    max_step_nxt     = max_step_r;
    angle_nxt        = angle_r;
    dist_nxt         = dist_r;
    scan_nxt         = scan_r;
    quot_nxt         = quot_r;
    z0_nxt           = z0_r;
    sn_nxt           = sn_r;
    cs_nxt           = cs_r;
    to_x_nxt         = to_x_r;
    to_y_nxt         = to_y_r;
    prev_col_nxt     = prev_col_r;
    prev_row_nxt     = prev_row_r;
    prev_bearing_nxt = prev_bearing_r;
    prev_pos_nxt     = prev_pos_r;
    have_prev_nxt    = have_prev_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:          scale_nxt    = cfg_wdata[SCALE_W-1:0];
        REG_ORIGIN_X:       origin_x_nxt = cfg_wdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y:       origin_y_nxt = cfg_wdata[ORIGIN_W-1:0];
        REG_Y_OFFSET:       y_offset_nxt = $signed(cfg_wdata[YOFF_W-1:0]);
        REG_MAX_ANGLE_STEP: max_step_nxt = cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          angle_nxt = in_data.angle;
          dist_nxt  = in_data.distance;
          scan_nxt  = in_data.scan_start;
          state_nxt = T_QUOT;
        end
      end
      T_QUOT: begin
        quot_nxt  = qprod[RECIP_SH +: ANGLE_W];
        state_nxt = T_REM;
      end
      T_REM: begin
        z0_nxt    = Z_W'(rem) << Z_SHIFT;
        state_nxt = T_CSTART;
      end
      T_CSTART: state_nxt = T_CWAIT;
      T_CWAIT: begin
        if (cord_done) state_nxt = T_MAP;
      end
      T_MAP: begin
        // The quadrant of the reduced bearing is the quotient mod 4.
        unique case (quot_r[1:0])
          QUAD_FIRST:  begin sn_nxt = cord_sin;  cs_nxt = cord_cos;  end
          QUAD_SECOND: begin sn_nxt = cord_cos;  cs_nxt = -cord_sin; end
          QUAD_THIRD:  begin sn_nxt = -cord_sin; cs_nxt = -cord_cos; end
          default:     begin sn_nxt = -cord_cos; cs_nxt = cord_sin;  end
        endcase
        state_nxt = T_PX;
      end
      T_PX: state_nxt = T_PXW;
      T_PXW: begin
        if (proj_done) begin
          to_x_nxt  = proj_coord;
          state_nxt = T_PY;
        end
      end
      T_PY: state_nxt = T_PYW;
      T_PYW: begin
        if (proj_done) begin
          to_y_nxt  = proj_coord;
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.from_x        = first ? to_x_r : prev_col_r;
          out_data_nxt.from_y        = first ? to_y_r : prev_row_r;
          out_data_nxt.to_x          = to_x_r;
          out_data_nxt.to_y          = to_y_r;
          out_data_nxt.draw_segment  = draw;
          prev_col_nxt               = to_x_r;
          prev_row_nxt               = to_y_r;
          prev_bearing_nxt           = angle_r;
          prev_pos_nxt               = (dist_r != '0);
          have_prev_nxt              = 1'b1;
          state_nxt                  = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= T_IDLE;
      out_valid_r    <= 1'b0;
      scale_r        <= SCALE_RESET;
      origin_x_r     <= ORIGIN_X_RESET;
      origin_y_r     <= ORIGIN_Y_RESET;
      y_offset_r     <= '0;
      max_step_r     <= MAX_STEP_RESET;
      prev_col_r     <= '0;
      prev_row_r     <= '0;
      prev_bearing_r <= '0;
      prev_pos_r     <= 1'b0;
      have_prev_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      scale_r        <= scale_nxt;
      origin_x_r     <= origin_x_nxt;
      origin_y_r     <= origin_y_nxt;
      y_offset_r     <= y_offset_nxt;
      max_step_r     <= max_step_nxt;
      prev_col_r     <= prev_col_nxt;
      prev_row_r     <= prev_row_nxt;
      prev_bearing_r <= prev_bearing_nxt;
      prev_pos_r     <= prev_pos_nxt;
      have_prev_r    <= have_prev_nxt;
    end
    angle_r    <= angle_nxt;
    dist_r     <= dist_nxt;
    scan_r     <= scan_nxt;
    quot_r     <= quot_nxt;
    z0_r       <= z0_nxt;
    sn_r       <= sn_nxt;
    cs_r       <= cs_nxt;
    to_x_r     <= to_x_nxt;
    to_y_r     <= to_y_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- sv/pcs_checker.sv -----
module pcs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pcs_pkg::out_item_t out_data
);
  import pcs_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A sample keeps the block busy; only the start of its conversion is checked.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again too soon after a beat");

  // A new result only appears at the end of a conversion.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a conversion in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind polar_scan_to_segments pcs_checker u_pcs_checker (.*);

// ----- tb/sv/tb_polar_scan_to_segments.sv -----
`timescale 1ns / 1ps

module tb_polar_scan_to_segments;
  import pcs_pkg::*;

  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam longint ROT_GAIN = 652032874;
  localparam int ROT_STEPS = 20;
  localparam longint ATAN_DEG [ROT_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };
  localparam int PROJ_SHIFT = 24 + SCALE_FRAC_BITS;
  localparam int N_DIRECTED = 20;
  localparam int HOLD_OFF = 600;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    in_item_t  sample;
    logic      typed;
    out_item_t segment;
  } dir_row_t;

  // Rows with zero range land exactly on the origin; those whose segment also starts there are typed in.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{15'd0, 16'd0, 1'b0}, 1'b1, '{16'sd240, 16'sd136, 16'sd240, 16'sd136, 1'b0}},
    '{'{15'd32767, 16'd0, 1'b0}, 1'b1, '{16'sd240, 16'sd136, 16'sd240, 16'sd136, 1'b0}},
    '{'{15'd0, 16'd65535, 1'b1}, 1'b0, '0},
    '{'{15'd64, 16'd65535, 1'b0}, 1'b0, '0},
    '{'{15'd5760, 16'd1000, 1'b0}, 1'b0, '0},
    '{'{15'd6399, 16'd1000, 1'b0}, 1'b0, '0},
    '{'{15'd7039, 16'd1000, 1'b0}, 1'b0, '0},
    '{'{15'd11520, 16'd1000, 1'b0}, 1'b0, '0},
    '{'{15'd17280, 16'd1000, 1'b0}, 1'b0, '0},
    '{'{15'd23039, 16'd1000, 1'b0}, 1'b0, '0},
    '{'{15'd23040, 16'd1000, 1'b0}, 1'b0, '0},
    '{'{15'd100, 16'd500, 1'b0}, 1'b0, '0},
    '{'{15'd200, 16'd0, 1'b0}, 1'b0, '0},
    '{'{15'd250, 16'd300, 1'b0}, 1'b0, '0},
    '{'{15'd300, 16'd300, 1'b1}, 1'b0, '0},
    '{'{15'd2880, 16'd12345, 1'b0}, 1'b0, '0},
    '{'{15'd16384, 16'd32768, 1'b0}, 1'b0, '0},
    '{'{15'd0, 16'd0, 1'b1}, 1'b1, '{16'sd240, 16'sd136, 16'sd240, 16'sd136, 1'b0}},
    '{'{15'd1, 16'd1, 1'b0}, 1'b0, '0},
    '{'{15'd5759, 16'd65535, 1'b0}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  polar_scan_to_segments DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Register shadow and remembered point.
  logic [SCALE_W-1:0] cur_scale = SCALE_RESET;
  logic [ORIGIN_W-1:0] cur_origin_x = ORIGIN_X_RESET;
  logic [ORIGIN_W-1:0] cur_origin_y = ORIGIN_Y_RESET;
  logic signed [YOFF_W-1:0] cur_y_offset = '0;
  logic [STEP_W-1:0] cur_max_step = MAX_STEP_RESET;
  logic signed [COORD_WIDTH-1:0] last_col = '0;
  logic signed [COORD_WIDTH-1:0] last_row = '0;
  logic [ANGLE_W-1:0] last_bearing = '0;
  logic last_echo = 1'b0;
  logic have_point = 1'b0;

  out_item_t expected_segments [$];
  int errors = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int long_hold_cycles = 0;

  function automatic void cordic_rotate(input int unsigned rem, output longint c,
                                        output longint s);
    longint z, x, y, dx, dy;
    z = longint'(rem) << (16 - ANGLE_FRAC_BITS);
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_DEG[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_DEG[i];
      end
    end
    c = x;
    s = y;
  endfunction

  // Range times a trig value times scale, rounded half away from zero.
  function automatic longint project_axis(logic [DIST_W-1:0] range_mm, longint trig);
    logic [63:0] mag, mag24, prod, rounded;
    mag = (trig < 0) ? -trig : trig;
    mag24 = (mag + 64'd32) >> 6;
    prod = 64'(range_mm) * mag24 * 64'(cur_scale);
    rounded = (prod + (64'd1 << (PROJ_SHIFT - 1))) >> PROJ_SHIFT;
    return (trig < 0) ? -longint'(rounded) : longint'(rounded);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic out_item_t predict_segment(in_item_t s);
    out_item_t r;
    int unsigned a, quad;
    longint cr, sr, sn, cs;
    int step;
    a = s.angle % FULL_TURN;
    quad = a / QUARTER;
    cordic_rotate(a % QUARTER, cr, sr);
    unique case (quad)
      0: begin sn = sr; cs = cr; end
      1: begin sn = cr; cs = -sr; end
      2: begin sn = -sr; cs = -cr; end
      default: begin sn = -cr; cs = sr; end
    endcase
    r.to_x = clamp_coord(project_axis(s.distance, sn) + longint'(cur_origin_x));
    r.to_y = clamp_coord(project_axis(s.distance, cs) + longint'(cur_origin_y)
                         + longint'(cur_y_offset));
    if (s.scan_start || !have_point) begin
      r.from_x = r.to_x;
      r.from_y = r.to_y;
      r.draw_segment = 1'b0;
    end else begin
      step = int'(s.angle) - int'(last_bearing);
      r.from_x = last_col;
      r.from_y = last_row;
      r.draw_segment = (s.distance != 0) && last_echo && (step < int'(cur_max_step));
    end
    last_col = r.to_x;
    last_row = r.to_y;
    last_bearing = s.angle;
    last_echo = (s.distance != 0);
    have_point = 1'b1;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_sample(in_item_t s, logic typed, out_item_t typed_segment);
    out_item_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = s;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = predict_segment(s);
    expected_segments.push_back(typed ? typed_segment : predicted);
    @(negedge clk);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    unique case (idx)
      REG_SCALE: cur_scale = value[SCALE_W-1:0];
      REG_ORIGIN_X: cur_origin_x = value[ORIGIN_W-1:0];
      REG_ORIGIN_Y: cur_origin_y = value[ORIGIN_W-1:0];
      REG_Y_OFFSET: cur_y_offset = value[YOFF_W-1:0];
      REG_MAX_ANGLE_STEP: cur_max_step = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_for_results(int extra);
    in_valid = 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(int phase);
    unique case (phase)
      1: begin
        set_register(REG_SCALE, 20'd1048575);
        set_register(REG_ORIGIN_X, 20'd1023);
        set_register(REG_ORIGIN_Y, 20'd1023);
        set_register(REG_Y_OFFSET, 20'd511);
        set_register(REG_MAX_ANGLE_STEP, 20'd23039);
      end
      2: begin
        set_register(REG_SCALE, 20'd0);
        set_register(REG_ORIGIN_X, 20'd0);
        set_register(REG_ORIGIN_Y, 20'd0);
        set_register(REG_Y_OFFSET, 20'h00200);
        set_register(REG_MAX_ANGLE_STEP, 20'd0);
      end
      default: begin
        // Full-width data also checks that the upper bits are dropped.
        set_register(REG_SCALE, $urandom_range(1) ? 20'($urandom_range(131071)) : 20'($urandom));
        set_register(REG_ORIGIN_X, 20'($urandom));
        set_register(REG_ORIGIN_Y, 20'($urandom));
        set_register(REG_Y_OFFSET, 20'($urandom));
        set_register(REG_MAX_ANGLE_STEP, 20'($urandom));
      end
    endcase
    set_register(CFG_IDX_W'(int'(REG_MAX_ANGLE_STEP) + 1 + $urandom_range(2)),
                 20'($urandom));
  endtask

  task automatic set_idle_mode(int mode);
    unique case (mode)
      0: begin sender_idle_pct = 16; receiver_idle_pct = 79; end
      1: begin sender_idle_pct = 79; receiver_idle_pct = 16; end
      default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
    endcase
  endtask

  // Mostly scans of rising bearings with random content, the rest unrelated noise.
  task automatic run_scans(int count);
    in_item_t s;
    int sent, len, bearing, span;
    bit wide;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 7) begin
        len = $urandom_range(8, 40);
        bearing = $urandom_range(0, 23039);
        wide = $urandom_range(3) == 0;
        span = int'(cur_max_step) + 128;
        for (int i = 0; i < len && sent < count; i++) begin
          if (i != 0) bearing = bearing + $urandom_range(0, span) - 32;
          s.angle = ANGLE_W'(bearing);
          s.scan_start = (i == 0);
          if ($urandom_range(7) == 0) s.distance = '0;
          else s.distance = wide ? DIST_W'($urandom_range(1, 65535))
                                 : DIST_W'($urandom_range(1, 4000));
          send_sample(s, 1'b0, '0);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len && sent < count; i++) begin
          s.angle = ANGLE_W'($urandom);
          s.distance = ($urandom_range(3) == 0) ? '0 : DIST_W'($urandom);
          s.scan_start = 1'($urandom_range(1));
          send_sample(s, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (long_hold_cycles > 0) begin
      out_stall <= 1'b1;
      long_hold_cycles <= long_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_segments.size() == 0) begin
        errors++;
        $display("%0t: segment with none expected: from (%0d,%0d) to (%0d,%0d) draw %0b",
                 $time, out_data.from_x, out_data.from_y, out_data.to_x, out_data.to_y,
                 out_data.draw_segment);
      end else begin
        want = expected_segments.pop_front();
        if (out_data !== want) begin
          errors++;
          $display("%0t: segment mismatch: expected from (%0d,%0d) to (%0d,%0d) draw %0b",
                   $time, want.from_x, want.from_y, want.to_x, want.to_y, want.draw_segment);
          $display("%0t:                      got from (%0d,%0d) to (%0d,%0d) draw %0b",
                   $time, out_data.from_x, out_data.from_y, out_data.to_x, out_data.to_y,
                   out_data.draw_segment);
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAIL polar_scan_to_segments");
    $finish;
  end

  initial begin
    set_idle_mode(0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].segment);

    // Results back up while samples keep coming, so the input has to stall.
    long_hold_cycles = HOLD_OFF;
    run_scans(300);

    for (int phase = 1; phase <= 5; phase++) begin
      wait_for_results(4);
      apply_settings(phase);
      set_idle_mode(phase % 3);
      run_scans(320);
    end

    wait_for_results(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("PASS polar_scan_to_segments");
    end else begin
      $display("FAIL polar_scan_to_segments");
    end
    $finish;
  end

endmodule

// ----- polar_scan_to_segments.f -----
sv/pcs_pkg.sv
sv/pcs_cordic.sv
sv/pcs_project.sv
sv/polar_scan_to_segments.sv
sv/pcs_checker.sv
tb/sv/tb_polar_scan_to_segments.sv
